// ----- rtl/hvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Haversine distance package
// Shared widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // Number of CORDIC micro-rotations in both the rotation and vectoring units.
    localparam int ITERATIONS = 24;

    // Result bits of the pipelined integer square root.
    localparam int SQ_BITS = 31;

    // Angle in degrees times 2^23.
    typedef logic signed [32:0] deg_t;
    // Sine or cosine in units of 2^-30.
    typedef logic signed [31:0] cq_t;
    // Angle in radians times 2^30.
    typedef logic signed [32:0] ang_t;
    // Square root operand and result.
    typedef logic [2*SQ_BITS-2:0] sqv_t;
    typedef logic [SQ_BITS-1:0] root_t;

    // Start value of the rotation: the reciprocal of the CORDIC gain limit in Q30.
    localparam cq_t CORDIC_GAIN = 32'sd652032874;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic ang_t atan_q30(input int idx);
        ang_t val;
        unique case (idx)
            0:  val = 33'sd843314856;
            1:  val = 33'sd497837829;
            2:  val = 33'sd263043836;
            3:  val = 33'sd133525158;
            4:  val = 33'sd67021686;
            5:  val = 33'sd33543515;
            6:  val = 33'sd16775850;
            7:  val = 33'sd8388437;
            8:  val = 33'sd4194282;
            9:  val = 33'sd2097149;
            10: val = 33'sd1048575;
            11: val = 33'sd524287;
            12: val = 33'sd262143;
            13: val = 33'sd131071;
            14: val = 33'sd65535;
            15: val = 33'sd32767;
            16: val = 33'sd16383;
            17: val = 33'sd8191;
            18: val = 33'sd4095;
            19: val = 33'sd2047;
            20: val = 33'sd1023;
            21: val = 33'sd511;
            22: val = 33'sd255;
            23: val = 33'sd127;
            24: val = 33'sd63;
            25: val = 33'sd31;
            26: val = 33'sd15;
            27: val = 33'sd7;
            28: val = 33'sd3;
            29: val = 33'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/haversine_distance_top.sv -----
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Distance in metres (Q8) between two points given in degrees (Q22).
//
//   Channel | Direction | Fields                          | Handshake
//   s_      | in        | lat_a, lon_a, lat_b, lon_b      | s_valid / s_ready
//   m_      | out       | distance                        | m_valid / m_ready
//
// One request enters every cycle while s_ready is high; each one passes the
// two unrolled CORDIC units and the 31-stage square root on its way out.
// Reset is synchronous and active low; it clears only valid bits.
// A held result stalls the pipeline only once the output skid register is
// also full; s_ready then drops until the output is taken.
// ----------------------------------------------------------------------------
module haversine_distance_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [29:0] s_lat_a,
    input  logic signed [30:0] s_lon_a,
    input  logic signed [29:0] s_lat_b,
    input  logic signed [30:0] s_lon_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [32:0] m_distance
);
    import hvd_pkg::*;

    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [29:0] RADIUS_CM  = 30'd636962875;
    localparam logic [27:0] DIST_RND   = 28'd209715200;
    localparam logic [32:0] DIST_RECIP = 33'd5497558138;
    localparam logic [6:0]  DIST_DIV   = 7'd25;
    localparam logic [6:0]  DIST_DIV2  = 7'd50;
    localparam logic [6:0]  DIST_DIV3  = 7'd75;
    localparam logic [34:0] DIST_MAX   = 35'd5122760000;

    logic en;

    // Input stage: half differences and the latitudes rescaled to Q23 degrees.
    deg_t dlat_reg, dlon_reg, plat_a_reg, plat_b_reg;
    logic v0_reg;

    // Sine/cosine lane outputs.
    cq_t  s_lat, s_lon, c_a, c_b, unused_s_a, unused_s_b, unused_c_lat, unused_c_lon;
    logic sc_valid;

    // Products and the haversine term.
    logic        [32:0] sl2_reg, so2_reg, t1_reg;
    logic        [32:0] sl2_next, so2_next;
    logic signed [33:0] cab_reg, cab_next;
    logic signed [37:0] t2_reg, t2_next;
    logic               v1_reg, v2_reg, v3_reg;
    sqv_t               sa_reg, sb_reg, sa_next, sb_next;

    // Square roots.
    root_t root_a, root_b;
    logic  sq_valid;

    // Vectoring CORDIC.
    logic signed [33:0] vx_reg [1:ITERATIONS];
    logic signed [33:0] vy_reg [1:ITERATIONS];
    ang_t               vz_reg [1:ITERATIONS];
    logic               vv_reg [1:ITERATIONS];
    logic signed [33:0] vx_cur [0:ITERATIONS-1];
    logic signed [33:0] vy_cur [0:ITERATIONS-1];
    ang_t               vz_cur [0:ITERATIONS-1];
    logic               vv_cur [0:ITERATIONS-1];

    // Distance scaling.
    logic [37:0] pd_reg, pd_next;
    logic [33:0] qe_reg, qe7_reg, qe_next;
    logic [6:0]  plo_reg, rem_reg, rem_next;
    logic        v4_reg, v5_reg, v6_reg;
    logic [32:0] dist_fin;

    // Output register and skid register.
    logic        m_valid_reg, m_valid_next, skid_valid_reg, skid_valid_next;
    logic [32:0] m_dist_reg, m_dist_next, skid_dist_reg, skid_dist_next;

    // The pipeline moves whenever the skid register is free.
    assign en      = !skid_valid_reg;
    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlat_reg   <= {{3{s_lat_b[29]}}, s_lat_b} - {{3{s_lat_a[29]}}, s_lat_a};
            dlon_reg   <= {{2{s_lon_b[30]}}, s_lon_b} - {{2{s_lon_a[30]}}, s_lon_a};
            plat_a_reg <= {{2{s_lat_a[29]}}, s_lat_a, 1'b0};
            plat_b_reg <= {{2{s_lat_b[29]}}, s_lat_b, 1'b0};
        end
    end

    hvd_sincos u_sc_lat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .deg(dlat_reg),
        .out_valid(sc_valid), .sin_val(s_lat), .cos_val(unused_c_lat)
    );
    hvd_sincos u_sc_lon (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .deg(dlon_reg),
        .out_valid(), .sin_val(s_lon), .cos_val(unused_c_lon)
    );
    hvd_sincos u_sc_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .deg(plat_a_reg),
        .out_valid(), .sin_val(unused_s_a), .cos_val(c_a)
    );
    hvd_sincos u_sc_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v0_reg), .deg(plat_b_reg),
        .out_valid(), .sin_val(unused_s_b), .cos_val(c_b)
    );

    // Squares and the cosine product, then the second product, then clamp.
    always_comb begin
        logic signed [63:0] p_sl, p_so, p_cab;
        p_sl  = s_lat * s_lat;
        p_so  = s_lon * s_lon;
        p_cab = c_a * c_b;
        sl2_next = p_sl[62:30];
        so2_next = p_so[62:30];
        cab_next = p_cab[63:30];
    end

    always_comb begin
        logic signed [67:0] p_t2;
        p_t2    = cab_reg * $signed({1'b0, so2_reg});
        t2_next = p_t2[67:30];
    end

    always_comb begin
        logic signed [38:0] asum;
        logic        [30:0] a;
        asum = {t2_reg[37], t2_reg} + $signed({6'd0, t1_reg});
        if (asum[38]) begin
            a = '0;
        end else if (asum > $signed({8'd0, ONE_Q30})) begin
            a = ONE_Q30;
        end else begin
            a = asum[30:0];
        end
        sa_next = {a, 30'd0};
        sb_next = {ONE_Q30 - a, 30'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= sc_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sl2_reg <= sl2_next;
            so2_reg <= so2_next;
            cab_reg <= cab_next;
            t1_reg  <= sl2_reg;
            t2_reg  <= t2_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
        end
    end

    hvd_isqrt u_sqrt_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .radicand(sa_reg),
        .out_valid(sq_valid), .root(root_a)
    );
    hvd_isqrt u_sqrt_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v3_reg), .radicand(sb_reg),
        .out_valid(), .root(root_b)
    );

    // Vectoring CORDIC from (sqrt(1-a), sqrt(a)) drives y toward zero.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_vec
        if (i == 0) begin : g_first
            assign vx_cur[i] = {3'b000, root_b};
            assign vy_cur[i] = {3'b000, root_a};
            assign vz_cur[i] = '0;
            assign vv_cur[i] = sq_valid;
        end else begin : g_next
            assign vx_cur[i] = vx_reg[i];
            assign vy_cur[i] = vy_reg[i];
            assign vz_cur[i] = vz_reg[i];
            assign vv_cur[i] = vv_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vv_reg[i+1] <= 1'b0;
            end else if (en) begin
                vv_reg[i+1] <= vv_cur[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!vy_cur[i][33]) begin
                    vx_reg[i+1] <= vx_cur[i] + (vy_cur[i] >>> i);
                    vy_reg[i+1] <= vy_cur[i] - (vx_cur[i] >>> i);
                    vz_reg[i+1] <= vz_cur[i] + atan_q30(i);
                end else begin
                    vx_reg[i+1] <= vx_cur[i] - (vy_cur[i] >>> i);
                    vy_reg[i+1] <= vy_cur[i] + (vx_cur[i] >>> i);
                    vz_reg[i+1] <= vz_cur[i] - atan_q30(i);
                end
            end
        end
    end

    // Central angle times radius, rounded and divided by 2^24 first.
    always_comb begin
        ang_t        zf;
        logic [31:0] cang;
        logic [61:0] dp;
        zf   = vz_reg[ITERATIONS];
        cang = zf[32] ? 32'd0 : {zf[30:0], 1'b0};
        dp   = 62'(cang) * 62'(RADIUS_CM) + 62'(DIST_RND);
        pd_next = dp[61:24];
    end

    // Divide by 25: reciprocal estimate, remainder, then correction.
    always_comb begin
        logic [65:0] prod;
        prod    = 66'(pd_reg[37:5]) * 66'(DIST_RECIP);
        qe_next = prod[65:32];
    end

    always_comb begin
        logic [38:0] m;
        m        = 39'(qe_reg) * 39'(DIST_DIV);
        rem_next = plo_reg - m[6:0];
    end

    always_comb begin
        logic [34:0] q;
        q = 35'(qe7_reg) + 35'(rem_reg >= DIST_DIV) + 35'(rem_reg >= DIST_DIV2)
          + 35'(rem_reg >= DIST_DIV3);
        dist_fin = (q > DIST_MAX) ? DIST_MAX[32:0] : q[32:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= vv_reg[ITERATIONS];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pd_reg  <= pd_next;
            qe_reg  <= qe_next;
            plo_reg <= pd_reg[6:0];
            qe7_reg <= qe_reg;
            rem_reg <= rem_next;
        end
    end

    // Output register with a skid register behind it.
    always_comb begin
        logic out_free;
        out_free        = !m_valid_reg || m_ready;
        m_valid_next    = m_valid_reg;
        m_dist_next     = m_dist_reg;
        skid_valid_next = skid_valid_reg;
        skid_dist_next  = skid_dist_reg;
        if (skid_valid_reg) begin
            if (out_free) begin
                m_valid_next    = 1'b1;
                m_dist_next     = skid_dist_reg;
                skid_valid_next = 1'b0;
            end
        end else if (v6_reg) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_dist_next  = dist_fin;
            end else begin
                skid_valid_next = 1'b1;
                skid_dist_next  = dist_fin;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_dist_reg    <= m_dist_next;
        skid_dist_reg <= skid_dist_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_dist_reg;

endmodule

// ----- rtl/hvd_sincos.sv -----
// ----------------------------------------------------------------------------
// Haversine sine/cosine lane
// Reduces a degree angle to [-90,90], converts it to Q30 radians and runs a
// fully unrolled rotation-mode CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module hvd_sincos (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  hvd_pkg::deg_t deg,
    output logic         out_valid,
    output hvd_pkg::cq_t sin_val,
    output hvd_pkg::cq_t cos_val
);
    import hvd_pkg::*;

    localparam logic signed [33:0] TURN_DEG23    = 34'sd3019898880;
    localparam logic signed [33:0] HALF_DEG23    = 34'sd1509949440;
    localparam logic signed [33:0] QUARTER_DEG23 = 34'sd754974720;
    // pi/180 scaled: round(mag * 6981317 / 3125000) gives Q30 radians.
    localparam logic [22:0] RAD_NUM   = 23'd6981317;
    localparam logic [20:0] RAD_RND   = 21'd1562500;
    localparam logic [32:0] RAD_RECIP = 33'd5764607523;
    localparam logic [21:0] RAD_DIV   = 22'd390625;
    localparam logic [21:0] RAD_DIV2  = 22'd781250;

    // Stage 1: reduced magnitude and sign flags.
    logic [29:0] mag_reg, mag_next;
    logic        nang1_reg, nang1_next, ncos1_reg, ncos1_next, v1_reg;

    // Stage 2: scaled product.
    logic [52:0] p_reg;
    logic        nang2_reg, ncos2_reg, v2_reg;

    // Stage 3: quotient estimate.
    logic [30:0] qe3_reg, qe3_next;
    logic [21:0] nlo_reg;
    logic        nang3_reg, ncos3_reg, v3_reg;

    // Stage 4: remainder for correction.
    logic [30:0] qe4_reg;
    logic [21:0] rem_reg, rem_next;
    logic        nang4_reg, ncos4_reg, v4_reg;

    // CORDIC stages.
    cq_t  cx_reg [0:ITERATIONS];
    cq_t  cy_reg [0:ITERATIONS];
    ang_t cz_reg [0:ITERATIONS];
    logic cn_reg [0:ITERATIONS];
    logic cv_reg [0:ITERATIONS];
    ang_t z_next;

    // Wrap into [-180,180) and fold into [-90,90].
    always_comb begin
        logic signed [33:0] w, r, f;
        logic [33:0] a;
        w = {deg[32], deg};
        if (w < -HALF_DEG23) begin
            r = w + TURN_DEG23;
        end else if (w >= HALF_DEG23) begin
            r = w - TURN_DEG23;
        end else begin
            r = w;
        end
        ncos1_next = 1'b0;
        if (r > QUARTER_DEG23) begin
            f = HALF_DEG23 - r;
            ncos1_next = 1'b1;
        end else if (r < -QUARTER_DEG23) begin
            f = -HALF_DEG23 - r;
            ncos1_next = 1'b1;
        end else begin
            f = r;
        end
        nang1_next = f[33];
        a = nang1_next ? 34'(-f) : 34'(f);
        mag_next = a[29:0];
    end

    // Quotient estimate from the top bits times a reciprocal.
    always_comb begin
        logic [63:0] prod;
        prod = 64'(p_reg[52:22]) * 64'(RAD_RECIP);
        qe3_next = prod[62:32];
    end

    // Remainder modulo 2^22; it stays below three divisors.
    always_comb begin
        logic [49:0] m;
        m = 50'(qe3_reg) * 50'(RAD_DIV);
        rem_next = nlo_reg - m[21:0];
    end

    // Correct the estimate and apply the sign.
    always_comb begin
        logic [30:0] q;
        q = qe4_reg + 31'(rem_reg >= RAD_DIV) + 31'(rem_reg >= RAD_DIV2);
        z_next = nang4_reg ? -ang_t'({2'b00, q}) : ang_t'({2'b00, q});
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            cv_reg[0] <= v4_reg;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= mag_next;
            nang1_reg <= nang1_next;
            ncos1_reg <= ncos1_next;
            p_reg     <= 53'(mag_reg) * 53'(RAD_NUM) + 53'(RAD_RND);
            nang2_reg <= nang1_reg;
            ncos2_reg <= ncos1_reg;
            qe3_reg   <= qe3_next;
            nlo_reg   <= p_reg[24:3];
            nang3_reg <= nang2_reg;
            ncos3_reg <= ncos2_reg;
            qe4_reg   <= qe3_reg;
            rem_reg   <= rem_next;
            nang4_reg <= nang3_reg;
            ncos4_reg <= ncos3_reg;
            cx_reg[0] <= CORDIC_GAIN;
            cy_reg[0] <= '0;
            cz_reg[0] <= z_next;
            cn_reg[0] <= ncos4_reg;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!cz_reg[i][32]) begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_q30(i);
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_q30(i);
                end
                cn_reg[i+1] <= cn_reg[i];
            end
        end
    end

    // The fold past a right angle negates the cosine.
    assign out_valid = cv_reg[ITERATIONS];
    assign sin_val   = cy_reg[ITERATIONS];
    assign cos_val   = cn_reg[ITERATIONS] ? -cx_reg[ITERATIONS] : cx_reg[ITERATIONS];

endmodule

// ----- rtl/hvd_isqrt.sv -----
// ----------------------------------------------------------------------------
// Haversine integer square root
// Pipelined digit-by-digit square root, rounded down, one result bit a stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hvd_pkg::sqv_t radicand,
    output logic          out_valid,
    output hvd_pkg::root_t root
);
    import hvd_pkg::*;

    sqv_t  rem_reg  [1:SQ_BITS];
    root_t root_reg [1:SQ_BITS];
    logic  v_reg    [1:SQ_BITS];
    sqv_t  rem_cur  [0:SQ_BITS-1];
    root_t root_cur [0:SQ_BITS-1];
    logic  v_cur    [0:SQ_BITS-1];

    for (genvar j = 0; j < SQ_BITS; j++) begin : g_bit
        localparam int K = SQ_BITS - 1 - j;
        logic [2*SQ_BITS:0] trial;

        // Stage inputs: the port for the first bit, the previous stage after.
        if (j == 0) begin : g_first
            assign rem_cur[j]  = radicand;
            assign root_cur[j] = '0;
            assign v_cur[j]    = in_valid;
        end else begin : g_next
            assign rem_cur[j]  = rem_reg[j];
            assign root_cur[j] = root_reg[j];
            assign v_cur[j]    = v_reg[j];
        end

        // Trial subtrahend (2*root + 2^K) * 2^K.
        assign trial = ((2*SQ_BITS+1)'(root_cur[j]) << (K + 1))
                     + ((2*SQ_BITS+1)'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_cur[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({2'b00, rem_cur[j]} >= trial) begin
                    rem_reg[j+1]  <= rem_cur[j] - trial[2*SQ_BITS-2:0];
                    root_reg[j+1] <= root_cur[j] | (SQ_BITS'(1) << K);
                end else begin
                    rem_reg[j+1]  <= rem_cur[j];
                    root_reg[j+1] <= root_cur[j];
                end
            end
        end
    end

    assign out_valid = v_reg[SQ_BITS];
    assign root      = root_reg[SQ_BITS];

endmodule

// ----- rtl/hvd_checker.sv -----
// ----------------------------------------------------------------------------
// Haversine distance port checker
// Watches the top-level ports for output range, reset and flow control.
// ----------------------------------------------------------------------------
module hvd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [32:0] m_distance
);

    // Reset empties the output side and opens the input.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty after reset");

    // A delivered distance never exceeds the saturation limit.
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_distance <= 33'd5122760000)
        else $error("distance above limit");

    // An accepted output frees the skid register, so input reopens.
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |=> s_ready)
        else $error("input stalled although output drains");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance))
        else $error("stalled result changed");

endmodule

bind haversine_distance_top hvd_checker u_hvd_checker (.*);
